>>> src/assert_macros.svh
// Assertion macros shared by the RTL that checks itself.
// No dependencies; include by bare file name inside a module body.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");

// Next-cycle implication, disabled during reset.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`endif

>>> src/wsse_pkg.sv
// Types and constants for the wall sensor scan and steering error block.
// No dependencies.
package wsse_pkg;

  localparam int SAMPLE_W = 12;
  localparam int ERR_W    = 13;
  localparam int STEER_W  = 14;
  localparam int CFG_IDX_W = 3;
  localparam int IN_DATA_W  = 16;
  localparam int OUT_DATA_W = 40;

  localparam logic [SAMPLE_W-1:0] FULL_SCALE = 12'hFFF;

  // Register reset values
  localparam logic [SAMPLE_W-1:0] WALL_THRESH_RST = 12'd1000;
  localparam logic [SAMPLE_W-1:0] CTRL_THRESH_RST = 12'd1200;
  localparam logic [SAMPLE_W-1:0] REF_RST         = 12'd1500;

  // Scan order of the sensors
  typedef enum logic [1:0] {
    SEN_FRONT_LEFT  = 2'd0,
    SEN_RIGHT       = 2'd1,
    SEN_FRONT_RIGHT = 2'd2,
    SEN_LEFT        = 2'd3
  } sensor_t;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_WALL_THRESH_RIGHT       = 3'd0,
    REG_WALL_THRESH_LEFT        = 3'd1,
    REG_WALL_THRESH_FRONT_RIGHT = 3'd2,
    REG_WALL_THRESH_FRONT_LEFT  = 3'd3,
    REG_CTRL_THRESH_RIGHT       = 3'd4,
    REG_CTRL_THRESH_LEFT        = 3'd5,
    REG_REF_RIGHT               = 3'd6,
    REG_REF_LEFT                = 3'd7
  } cfg_reg_t;

endpackage

>>> src/wall_sensor_scan_and_steering_error.sv
// Wall sensor scan and steering error: the whole block in one module.
// Depends on wsse_pkg and assert_macros.svh.
//
// Takes one ADC sample per cycle and returns one result per sample, in the
// cycle after the request is accepted, from a single output register. Sensors
// are scanned front-left, right, front-right, left; each gets a dummy sample
// (captured = 0, value reads 0) followed by a captured one. The captured value
// (forced to full scale when conversion_ok is low) updates the wall flags and,
// for the side sensors, the control flag and side error. steering_error is
// built from the updated side errors. The input is held off only while the
// output register is full and not taken; the compare, subtract and final
// add between the input and the output register set the cycle time.
module wall_sensor_scan_and_steering_error (
  input  logic                              clk,
  input  logic                              rst,
  // Sample input
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // [11:0] sample, [15:12] zero
  input  logic [wsse_pkg::IN_DATA_W-1:0]    s_axis_tdata,
  // [0] conversion_ok
  input  logic                              s_axis_tuser,
  // Result output
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // [1:0] sensor_select, [3:2] captured_sensor, [15:4] captured_value,
  // [16] wall_right, [17] wall_left, [18] wall_front_right,
  // [19] wall_front_left, [20] control_right, [21] control_left,
  // [35:22] steering_error, [39:36] zero
  output logic [wsse_pkg::OUT_DATA_W-1:0]   m_axis_tdata,
  // [0] captured
  output logic                              m_axis_tuser,
  // Configuration write port
  input  logic                              cfg_we,
  input  logic [wsse_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [wsse_pkg::SAMPLE_W-1:0]     cfg_data
);
  import wsse_pkg::*;
  `include "assert_macros.svh"

  // Configuration registers
  logic [SAMPLE_W-1:0] wall_thresh_right, wall_thresh_left;
  logic [SAMPLE_W-1:0] wall_thresh_front_right, wall_thresh_front_left;
  logic [SAMPLE_W-1:0] ctrl_thresh_right, ctrl_thresh_left;
  logic [SAMPLE_W-1:0] ref_right, ref_left;

  // Scan state
  logic [1:0]              scan_index, scan_index_next;
  logic                    dummy_done, dummy_done_next;
  logic signed [ERR_W-1:0] side_err_right, side_err_right_next;
  logic signed [ERR_W-1:0] side_err_left, side_err_left_next;
  logic wall_right, wall_right_next, wall_left, wall_left_next;
  logic wall_front_right, wall_front_right_next;
  logic wall_front_left, wall_front_left_next;
  logic control_right, control_right_next, control_left, control_left_next;

  // Result register
  logic [1:0]              res_sensor_select;
  logic                    res_captured;
  logic [1:0]              res_captured_sensor;
  logic [SAMPLE_W-1:0]     res_captured_value;
  logic signed [STEER_W-1:0] res_steer;
  logic                    res_valid;

  logic                    in_acc;
  sensor_t                 sensor;
  logic [SAMPLE_W-1:0]     value;
  logic [SAMPLE_W-1:0]     cap_value;
  logic signed [STEER_W-1:0] steer;

  assign s_axis_tready = !res_valid || m_axis_tready;
  assign in_acc        = s_axis_tvalid && s_axis_tready;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      wall_thresh_right       <= WALL_THRESH_RST;
      wall_thresh_left        <= WALL_THRESH_RST;
      wall_thresh_front_right <= WALL_THRESH_RST;
      wall_thresh_front_left  <= WALL_THRESH_RST;
      ctrl_thresh_right       <= CTRL_THRESH_RST;
      ctrl_thresh_left        <= CTRL_THRESH_RST;
      ref_right               <= REF_RST;
      ref_left                <= REF_RST;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_WALL_THRESH_RIGHT:       wall_thresh_right       <= cfg_data;
        REG_WALL_THRESH_LEFT:        wall_thresh_left        <= cfg_data;
        REG_WALL_THRESH_FRONT_RIGHT: wall_thresh_front_right <= cfg_data;
        REG_WALL_THRESH_FRONT_LEFT:  wall_thresh_front_left  <= cfg_data;
        REG_CTRL_THRESH_RIGHT:       ctrl_thresh_right       <= cfg_data;
        REG_CTRL_THRESH_LEFT:        ctrl_thresh_left        <= cfg_data;
        REG_REF_RIGHT:               ref_right               <= cfg_data;
        REG_REF_LEFT:                ref_left                <= cfg_data;
        default: ;
      endcase
    end
  end

  // Next scan state for the incoming sample
  always_comb begin
    sensor    = sensor_t'(scan_index);
    value     = s_axis_tuser ? s_axis_tdata[SAMPLE_W-1:0] : FULL_SCALE;
    cap_value = '0;
    scan_index_next       = scan_index;
    dummy_done_next       = 1'b1;
    side_err_right_next   = side_err_right;
    side_err_left_next    = side_err_left;
    wall_right_next       = wall_right;
    wall_left_next        = wall_left;
    wall_front_right_next = wall_front_right;
    wall_front_left_next  = wall_front_left;
    control_right_next    = control_right;
    control_left_next     = control_left;
    if (dummy_done) begin
      dummy_done_next = 1'b0;
      cap_value       = value;
      scan_index_next = scan_index + 2'd1;
      case (sensor)
        SEN_FRONT_LEFT: begin
          wall_front_left_next = value > wall_thresh_front_left;
        end
        SEN_RIGHT: begin
          wall_right_next    = value > wall_thresh_right;
          control_right_next = value > ctrl_thresh_right;
          side_err_right_next = control_right_next ?
            $signed({1'b0, value}) - $signed({1'b0, ref_right}) : '0;
        end
        SEN_FRONT_RIGHT: begin
          wall_front_right_next = value > wall_thresh_front_right;
        end
        SEN_LEFT: begin
          wall_left_next    = value > wall_thresh_left;
          control_left_next = value > ctrl_thresh_left;
          side_err_left_next = control_left_next ?
            $signed({1'b0, value}) - $signed({1'b0, ref_left}) : '0;
        end
        default: ;
      endcase
    end
  end

  // Combine the side errors into the steering error
  always_comb begin
    case ({control_left_next, control_right_next})
      2'b11: steer = $signed({side_err_right_next[ERR_W-1], side_err_right_next})
                   - $signed({side_err_left_next[ERR_W-1], side_err_left_next});
      2'b01: steer = $signed({side_err_right_next, 1'b0});
      2'b10: steer = $signed(STEER_W'(0)) - $signed({side_err_left_next, 1'b0});
      default: steer = '0;
    endcase
  end

  // Advance scan state on each accepted request
  always_ff @(posedge clk) begin
    if (rst) begin
      scan_index       <= '0;
      dummy_done       <= 1'b0;
      side_err_right   <= '0;
      side_err_left    <= '0;
      wall_right       <= 1'b0;
      wall_left        <= 1'b0;
      wall_front_right <= 1'b0;
      wall_front_left  <= 1'b0;
      control_right    <= 1'b0;
      control_left     <= 1'b0;
    end else if (in_acc) begin
      scan_index       <= scan_index_next;
      dummy_done       <= dummy_done_next;
      side_err_right   <= side_err_right_next;
      side_err_left    <= side_err_left_next;
      wall_right       <= wall_right_next;
      wall_left        <= wall_left_next;
      wall_front_right <= wall_front_right_next;
      wall_front_left  <= wall_front_left_next;
      control_right    <= control_right_next;
      control_left     <= control_left_next;
    end
  end

  // Output valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (in_acc) begin
      res_valid <= 1'b1;
    end else if (m_axis_tready) begin
      res_valid <= 1'b0;
    end
  end

  // Load the result payload
  always_ff @(posedge clk) begin
    if (in_acc) begin
      res_sensor_select   <= scan_index_next;
      res_captured        <= dummy_done;
      res_captured_sensor <= scan_index;
      res_captured_value  <= cap_value;
      res_steer           <= steer;
    end
  end

  assign m_axis_tvalid = res_valid;
  assign m_axis_tuser  = res_captured;
  assign m_axis_tdata  = {4'b0000, res_steer, control_left, control_right,
                          wall_front_left, wall_front_right, wall_left, wall_right,
                          res_captured_value, res_captured_sensor, res_sensor_select};

  // Checks
  `ASSERT_IMPLIES(a_stall_blocks_input, clk, rst,
    m_axis_tvalid && !m_axis_tready, !s_axis_tready)
  `ASSERT_IMPLIES(a_dummy_value_zero, clk, rst,
    m_axis_tvalid && !res_captured, res_captured_value == '0)
  `ASSERT_IMPLIES(a_no_control_no_steer, clk, rst,
    m_axis_tvalid && !control_right && !control_left, res_steer == '0)
  `ASSERT_NEXT(a_dummy_holds_scan, clk, rst,
    in_acc && !dummy_done, scan_index == $past(scan_index))

endmodule

>>> test/wsse_scan_checker.sv
`timescale 1ns / 1ps
// Result checker for the wall sensor scan and steering error block: watches the
// sample, result and register write ports, predicts every result and compares it.
// Depends on wsse_pkg.
module wsse_scan_checker (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  input  logic                            s_tready,
  // [11:0] sample, [15:12] zero
  input  logic [wsse_pkg::IN_DATA_W-1:0]  s_tdata,
  // [0] conversion_ok
  input  logic                            s_tuser,
  input  logic                            m_tvalid,
  input  logic                            m_tready,
  // [1:0] sensor_select, [3:2] captured_sensor, [15:4] captured_value,
  // [19:16] wall right/left/front right/front left, [21:20] control right/left,
  // [35:22] steering_error, [39:36] zero
  input  logic [wsse_pkg::OUT_DATA_W-1:0] m_tdata,
  // [0] captured
  input  logic                            m_tuser,
  input  logic                            cfg_we,
  input  logic [wsse_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [wsse_pkg::SAMPLE_W-1:0]   cfg_data,
  output int                              fail_count,
  output int                              pending,
  output int                              checked
);
  import wsse_pkg::*;

  typedef struct packed {
    logic [1:0]         next_sensor;
    logic               captured;
    logic [1:0]         sensor;
    logic [SAMPLE_W-1:0] value;
    logic [3:0]         walls;   // right, left, front right, front left from bit 0
    logic [1:0]         usable;  // right, left from bit 0
    logic [STEER_W-1:0] steer;
  } scan_result_t;

  scan_result_t               expected_q[$];
  logic [SAMPLE_W-1:0]        cfg_val [8];
  sensor_t                    scan_pos;
  logic                       capture_next;
  logic signed [ERR_W-1:0]    err_right;
  logic signed [ERR_W-1:0]    err_left;
  logic [3:0]                 walls;
  logic [1:0]                 usable;
  int                         fails = 0;
  int                         done = 0;

  // Advance the scan by one sample and return the result it should produce
  function automatic scan_result_t advance_scan(input logic [SAMPLE_W-1:0] smp,
                                                input logic ok);
    scan_result_t        r;
    logic [SAMPLE_W-1:0] v;
    int                  diff;
    int                  steer;
    r = '0;
    r.sensor = scan_pos;
    if (!capture_next) begin
      capture_next = 1'b1;
    end else begin
      capture_next = 1'b0;
      r.captured = 1'b1;
      v = ok ? smp : FULL_SCALE;
      r.value = v;
      case (scan_pos)
        SEN_FRONT_LEFT: begin
          walls[3] = v > cfg_val[REG_WALL_THRESH_FRONT_LEFT];
        end
        SEN_RIGHT: begin
          walls[0] = v > cfg_val[REG_WALL_THRESH_RIGHT];
          usable[0] = v > cfg_val[REG_CTRL_THRESH_RIGHT];
          diff = int'(v) - int'(cfg_val[REG_REF_RIGHT]);
          err_right = usable[0] ? diff[ERR_W-1:0] : '0;
        end
        SEN_FRONT_RIGHT: begin
          walls[2] = v > cfg_val[REG_WALL_THRESH_FRONT_RIGHT];
        end
        default: begin
          walls[1] = v > cfg_val[REG_WALL_THRESH_LEFT];
          usable[1] = v > cfg_val[REG_CTRL_THRESH_LEFT];
          diff = int'(v) - int'(cfg_val[REG_REF_LEFT]);
          err_left = usable[1] ? diff[ERR_W-1:0] : '0;
        end
      endcase
      scan_pos = sensor_t'(scan_pos + 2'd1);
    end
    // Steering from whichever sides are usable; a lone side counts double
    case (usable)
      2'b11:   steer = int'(err_right) - int'(err_left);
      2'b01:   steer = 2 * int'(err_right);
      2'b10:   steer = -2 * int'(err_left);
      default: steer = 0;
    endcase
    r.next_sensor = scan_pos;
    r.walls = walls;
    r.usable = usable;
    r.steer = steer[STEER_W-1:0];
    return r;
  endfunction

  task automatic check_field(input string name, input int want, input int got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fails++;
    end
  endtask

  // Compare results, queue predictions, track register writes
  always @(posedge clk) begin
    scan_result_t want;
    if (rst) begin
      expected_q.delete();
      scan_pos = SEN_FRONT_LEFT;
      capture_next = 1'b0;
      err_right = '0;
      err_left = '0;
      walls = '0;
      usable = '0;
      cfg_val[REG_WALL_THRESH_RIGHT]       = WALL_THRESH_RST;
      cfg_val[REG_WALL_THRESH_LEFT]        = WALL_THRESH_RST;
      cfg_val[REG_WALL_THRESH_FRONT_RIGHT] = WALL_THRESH_RST;
      cfg_val[REG_WALL_THRESH_FRONT_LEFT]  = WALL_THRESH_RST;
      cfg_val[REG_CTRL_THRESH_RIGHT]       = CTRL_THRESH_RST;
      cfg_val[REG_CTRL_THRESH_LEFT]        = CTRL_THRESH_RST;
      cfg_val[REG_REF_RIGHT]               = REF_RST;
      cfg_val[REG_REF_LEFT]                = REF_RST;
    end else begin
      if (m_tvalid && m_tready) begin
        done++;
        if (expected_q.size() == 0) begin
          $error("result with no request outstanding");
          fails++;
        end else begin
          want = expected_q.pop_front();
          check_field("sensor_select", int'(want.next_sensor), int'(m_tdata[1:0]));
          check_field("captured", int'(want.captured), int'(m_tuser));
          check_field("captured_sensor", int'(want.sensor), int'(m_tdata[3:2]));
          check_field("captured_value", int'(want.value), int'(m_tdata[15:4]));
          check_field("wall_right", int'(want.walls[0]), int'(m_tdata[16]));
          check_field("wall_left", int'(want.walls[1]), int'(m_tdata[17]));
          check_field("wall_front_right", int'(want.walls[2]), int'(m_tdata[18]));
          check_field("wall_front_left", int'(want.walls[3]), int'(m_tdata[19]));
          check_field("control_right", int'(want.usable[0]), int'(m_tdata[20]));
          check_field("control_left", int'(want.usable[1]), int'(m_tdata[21]));
          check_field("steering_error", int'($signed(want.steer)),
                      int'($signed(m_tdata[35:22])));
        end
      end
      if (s_tvalid && s_tready)
        expected_q.push_back(advance_scan(s_tdata[SAMPLE_W-1:0], s_tuser));
      if (cfg_we)
        cfg_val[cfg_index] = cfg_data;
    end
    pending    <= expected_q.size();
    fail_count <= fails;
    checked    <= done;
  end

endmodule

>>> test/tb_wall_sensor_scan_and_steering_error.sv
`timescale 1ns / 1ps
// Top of the wall sensor scan testbench: clock, reset, bursty sample requests,
// receiver stalls and register phases. Depends on wsse_pkg, the block and wsse_scan_checker.
module tb_wall_sensor_scan_and_steering_error;
  import wsse_pkg::*;

  localparam int CYCLE_LIMIT = 200000;

  typedef enum int {
    STALL_NONE,
    STALL_COIN,
    STALL_SPARSE,
    STALL_LIGHT
  } stall_mode_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  // [11:0] sample, [15:12] zero
  logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
  // [0] conversion_ok
  logic                  s_axis_tuser = 1'b0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  // [1:0] sensor_select, [3:2] captured_sensor, [15:4] captured_value, [21:16] flags,
  // [35:22] steering_error, [39:36] zero
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  // [0] captured
  logic                  m_axis_tuser;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [SAMPLE_W-1:0]   cfg_data = '0;

  int                    check_fails;
  int                    results_left;
  int                    results_checked;
  int                    cycle_cnt = 0;
  int                    sent = 0;
  int                    burst_left = 0;
  int                    settings_used = 1;
  int                    stall_cnt = 0;
  stall_mode_t           stall_mode = STALL_NONE;
  logic [SAMPLE_W-1:0]   setting [8];

  wall_sensor_scan_and_steering_error u_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  wsse_scan_checker u_scan_check (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_axis_tvalid),
    .s_tready   (s_axis_tready),
    .s_tdata    (s_axis_tdata),
    .s_tuser    (s_axis_tuser),
    .m_tvalid   (m_axis_tvalid),
    .m_tready   (m_axis_tready),
    .m_tdata    (m_axis_tdata),
    .m_tuser    (m_axis_tuser),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .fail_count (check_fails),
    .pending    (results_left),
    .checked    (results_checked)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Give up on a hung run
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // Receiver stalls: switch to a randomly chosen stall pattern when the current one runs out
  always @(negedge clk) begin
    if (stall_cnt == 0) begin
      stall_mode = stall_mode_t'($urandom_range(0, 3));
      stall_cnt = $urandom_range(20, 80);
    end
    stall_cnt = stall_cnt - 1;
    case (stall_mode)
      STALL_NONE:   m_axis_tready <= 1'b1;
      STALL_COIN:   m_axis_tready <= 1'($urandom_range(0, 1));
      STALL_SPARSE: m_axis_tready <= (stall_cnt % 4 == 0);
      default:      m_axis_tready <= ($urandom_range(0, 4) != 0);
    endcase
  end

  // Send one sample request; open a new burst after a random gap when the last one ran out
  task automatic send_sample(input logic [SAMPLE_W-1:0] smp, input logic ok);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 90) : $urandom_range(1, 12);
      if (gap > 0) begin
        @(negedge clk);
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    @(negedge clk);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {{(IN_DATA_W-SAMPLE_W){1'b0}}, smp};
    s_axis_tuser  <= ok;
    do @(posedge clk); while (!s_axis_tready);
    burst_left--;
    sent++;
  endtask

  // Dummy conversion with junk data, then the real capture
  task automatic sample_pair(input logic [SAMPLE_W-1:0] smp, input logic ok);
    send_sample(SAMPLE_W'($urandom_range(0, 4095)), 1'($urandom_range(0, 1)));
    send_sample(smp, ok);
  endtask

  // Pick a capture value, mostly close to the thresholds that matter for this sensor
  function automatic logic [SAMPLE_W-1:0] pick_sample(input sensor_t sen);
    int wall_t;
    int ctrl_t;
    int ref_v;
    int base;
    case (sen)
      SEN_FRONT_LEFT: begin
        wall_t = setting[REG_WALL_THRESH_FRONT_LEFT];
        ctrl_t = wall_t;
        ref_v  = wall_t;
      end
      SEN_RIGHT: begin
        wall_t = setting[REG_WALL_THRESH_RIGHT];
        ctrl_t = setting[REG_CTRL_THRESH_RIGHT];
        ref_v  = setting[REG_REF_RIGHT];
      end
      SEN_FRONT_RIGHT: begin
        wall_t = setting[REG_WALL_THRESH_FRONT_RIGHT];
        ctrl_t = wall_t;
        ref_v  = wall_t;
      end
      default: begin
        wall_t = setting[REG_WALL_THRESH_LEFT];
        ctrl_t = setting[REG_CTRL_THRESH_LEFT];
        ref_v  = setting[REG_REF_LEFT];
      end
    endcase
    case ($urandom_range(0, 9))
      0, 1, 2: return SAMPLE_W'($urandom_range(0, 4095));
      3, 4:    base = wall_t;
      5, 6:    base = ctrl_t;
      7:       return $urandom_range(0, 1) ? FULL_SCALE : '0;
      default: base = ref_v + int'($urandom_range(0, 400)) - 200;
    endcase
    base = base + int'($urandom_range(0, 6)) - 3;
    if (base < 0) base = 0;
    if (base > 4095) base = 4095;
    return base[SAMPLE_W-1:0];
  endfunction

  // Drop valid and hold until every result is back
  task automatic drain();
    @(negedge clk);
    s_axis_tvalid <= 1'b0;
    burst_left = 0;
    do @(posedge clk); while (results_left != 0);
    repeat (3) @(posedge clk);
  endtask

  // Random samples in scan order, then drain
  task automatic run_random(input int count);
    for (int i = 0; i < count; i++) begin
      if (sent % 2 == 0)
        send_sample(SAMPLE_W'($urandom_range(0, 4095)), 1'($urandom_range(0, 1)));
      else
        send_sample(pick_sample(sensor_t'((sent / 2) % 4)), $urandom_range(0, 7) != 0);
    end
    drain();
  endtask

  // Write all eight registers from the current settings; block is idle here
  task automatic load_settings();
    for (int i = 0; i < 8; i++) begin
      @(negedge clk);
      cfg_we    <= 1'b1;
      cfg_index <= cfg_reg_t'(i);
      cfg_data  <= setting[i];
    end
    @(negedge clk);
    cfg_we <= 1'b0;
    settings_used++;
  endtask

  initial begin
    setting[REG_WALL_THRESH_RIGHT]       = WALL_THRESH_RST;
    setting[REG_WALL_THRESH_LEFT]        = WALL_THRESH_RST;
    setting[REG_WALL_THRESH_FRONT_RIGHT] = WALL_THRESH_RST;
    setting[REG_WALL_THRESH_FRONT_LEFT]  = WALL_THRESH_RST;
    setting[REG_CTRL_THRESH_RIGHT]       = CTRL_THRESH_RST;
    setting[REG_CTRL_THRESH_LEFT]        = CTRL_THRESH_RST;
    setting[REG_REF_RIGHT]               = REF_RST;
    setting[REG_REF_LEFT]                = REF_RST;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Scan 1: all captures at zero, nothing usable
    sample_pair(12'd0, 1'b1);
    sample_pair(12'd0, 1'b1);
    sample_pair(12'd0, 1'b1);
    sample_pair(12'd0, 1'b1);
    // Scan 2: full scale front left, right wall but not usable, two failed conversions
    // (left becomes the only usable side)
    sample_pair(12'd4095, 1'b1);
    sample_pair(12'd1100, 1'b1);
    sample_pair(12'd0, 1'b0);
    sample_pair(12'd0, 1'b0);
    // Scan 3: values right at the thresholds; both usable, then right alone
    sample_pair(12'd1000, 1'b1);
    sample_pair(12'd1300, 1'b1);
    sample_pair(12'd1001, 1'b1);
    sample_pair(12'd1200, 1'b1);
    drain();

    // Reset register values
    run_random(100);

    // Everything at zero: any nonzero capture is a wall and usable
    for (int i = 0; i < 8; i++) setting[i] = '0;
    load_settings();
    run_random(100);

    // Everything at full scale: no walls, no usable side
    for (int i = 0; i < 8; i++) setting[i] = FULL_SCALE;
    load_settings();
    run_random(80);

    // Zero thresholds with full-scale references: most negative side errors
    for (int i = 0; i < 8; i++) setting[i] = '0;
    setting[REG_REF_RIGHT] = FULL_SCALE;
    setting[REG_REF_LEFT]  = FULL_SCALE;
    load_settings();
    run_random(80);

    // Random settings
    repeat (2) begin
      for (int i = 0; i < 8; i++) setting[i] = SAMPLE_W'($urandom_range(0, 4095));
      load_settings();
      run_random(70);
    end

    $display("Summary: %0d samples (%0d captures) under %0d register settings",
             sent, sent / 2, settings_used);
    $display("Summary: %0d results compared field by field", results_checked);
    if (check_fails == 0 && results_left == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

endmodule

>>> sim.f
+incdir+src
src/wsse_pkg.sv
src/wall_sensor_scan_and_steering_error.sv
test/wsse_scan_checker.sv
test/tb_wall_sensor_scan_and_steering_error.sv
